>>> src/prime_sieve_counter_unit_macros.svh
// Assertion macros shared by the prime sieve counter RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef PRIME_SIEVE_COUNTER_UNIT_MACROS_SVH
`define PRIME_SIEVE_COUNTER_UNIT_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define PSC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Check that cons holds in the cycle after ante holds.
`define PSC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

>>> src/psc_pkg.sv
// Shared constants and types of the prime sieve counter.
// No dependencies; imported by the RAM-facing core and the top level.
package psc_pkg;

   // Size of the prime-mark store (numbers 0 .. MAX_N-1)
   localparam int MAX_N   = 65536;
   localparam int ADDR_W  = $clog2(MAX_N);
   // Width for candidates, stops and multiples: holds up to 2*MAX_N-1
   localparam int NUM_W   = ((ADDR_W >= 16) ? ADDR_W : 16) + 1;
   localparam int SQ_W    = 2 * NUM_W;
   localparam int FIELD_W = 16;
   localparam int COUNT_W = 17;

   localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
   localparam logic [NUM_W-1:0]   STOP_LIMIT = NUM_W'(MAX_N - 1);
   localparam logic [NUM_W-1:0]   FIRST_CAND = NUM_W'(2);

   // Configuration register indexes
   localparam logic REG_RANGE_START = 1'b0;
   localparam logic REG_RANGE_STOP  = 1'b1;

   typedef struct packed {
      logic [NUM_W-1:0] start;
      logic [NUM_W-1:0] stop;
   } psc_cfg_type;

   typedef struct packed {
      logic [FIELD_W-1:0] candidate;
      logic               prime_flag;
      logic               counted;
      logic [COUNT_W-1:0] prime_count;
      logic               done_res;
   } psc_result_type;

endpackage

>>> src/psc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module psc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/psc_core.sv
// Sieve sequencer: clearing sweep, candidate read, multiple marking, count.
// Depends on psc_pkg and psc_ram.
module psc_core (
   input  logic                    clock,
   input  logic                    reset,
   input  psc_pkg::psc_cfg_type    cfg,
   input  logic                    item_valid,
   input  logic                    item_restart,
   output logic                    item_ready,
   input  logic                    res_free,
   output logic                    res_valid,
   output psc_pkg::psc_result_type res
);
   import psc_pkg::*;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_READ   = 6'b000100,
      ST_CHECK  = 6'b001000,
      ST_MARK   = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [NUM_W-1:0]   next_cand_ff, next_cand_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [NUM_W-1:0]   cand_ff, cand_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [NUM_W-1:0]   mult_ff, mult_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic               restart_ff, restart_in;
   psc_result_type     res_ff, res_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic               wr_data;
   logic [ADDR_W-1:0]  rd_addr;
   logic               rd_data;

   logic [NUM_W-1:0]   mult_next;
   logic               cnt_hit;
   logic [COUNT_W-1:0] count_next;

   // prime-mark store: 1 = still prime
   psc_ram #(
      .WIDTH (1),
      .DEPTH (MAX_N)
   ) u_marks (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // hold the read address on the current candidate so read data stays put
   assign rd_addr   = (state_ff == ST_IDLE) ? next_cand_ff[ADDR_W-1:0]
                                            : cand_ff[ADDR_W-1:0];
   assign mult_next = mult_ff + cand_ff;
   assign cnt_hit   = rd_data && (cand_ff >= cfg.start);
   assign count_next = (cnt_hit && (count_ff != COUNT_MAX)) ?
                       COUNT_W'(count_ff + 1'b1) : count_ff;

   assign item_ready = (state_ff == ST_IDLE);
   assign res_valid  = (state_ff == ST_FINISH) && res_free;
   assign res        = res_ff;

   // sequencer: every store access is issued by one state, so reads and
   // marks of the same entry never overlap
   always_comb begin
      state_in     = state_ff;
      next_cand_in = next_cand_ff;
      count_in     = count_ff;
      cand_in      = cand_ff;
      sq_in        = sq_ff;
      mult_in      = mult_ff;
      clr_addr_in  = clr_addr_ff;
      restart_in   = restart_ff;
      res_in       = res_ff;
      wr_en        = 1'b0;
      wr_addr      = mult_ff[ADDR_W-1:0];
      wr_data      = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            // sweep the store back to all prime
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = 1'b1;
            clr_addr_in = ADDR_W'(clr_addr_ff + 1'b1);
            if (clr_addr_ff == ADDR_W'(MAX_N - 1)) begin
               state_in = restart_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (item_valid) begin
               if (item_restart) begin
                  next_cand_in = FIRST_CAND;
                  count_in     = '0;
                  res_in       = '0;
                  restart_in   = 1'b1;
                  clr_addr_in  = '0;
                  state_in     = ST_CLEAR;
               end else if (next_cand_ff > cfg.stop) begin
                  res_in             = '0;
                  res_in.prime_count = count_ff;
                  res_in.done_res    = 1'b1;
                  state_in           = ST_FINISH;
               end else begin
                  cand_in  = next_cand_ff;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            sq_in    = cand_ff * cand_ff;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            count_in           = count_next;
            next_cand_in       = NUM_W'(cand_ff + 1'b1);
            res_in.candidate   = cand_ff[FIELD_W-1:0];
            res_in.prime_flag  = rd_data;
            res_in.counted     = cnt_hit;
            res_in.prime_count = count_next;
            res_in.done_res    = (cand_ff >= cfg.stop);
            if (rd_data && (sq_ff <= SQ_W'(cfg.stop))) begin
               mult_in  = sq_ff[NUM_W-1:0];
               state_in = ST_MARK;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_MARK: begin
            // clear one multiple per cycle
            wr_en   = 1'b1;
            mult_in = mult_next;
            if (mult_next > cfg.stop) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (res_free) begin
               restart_in = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         next_cand_ff <= FIRST_CAND;
         count_ff     <= '0;
         clr_addr_ff  <= '0;
         restart_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_cand_ff <= next_cand_in;
         count_ff     <= count_in;
         clr_addr_ff  <= clr_addr_in;
         restart_ff   <= restart_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
      sq_ff   <= sq_in;
      mult_ff <= mult_in;
      res_ff  <= res_in;
   end

endmodule

>>> src/prime_sieve_counter_unit.sv
// Top level of the prime sieve counter: configuration registers, output word
// register and handshake. Depends on psc_pkg, psc_core and the assertion macros.
//
// Each accepted word steps a sieve of Eratosthenes by one candidate, from 2
// up to the stop value, and returns one result word. A candidate that marks
// nothing goes through issue, store read, check and deliver; a prime whose
// square does not exceed the stop also clears its multiples from its square
// up to the stop through the single write port of the mark store, one entry a
// cycle. A word after done returns a done result with no store read. After
// reset and after every restart word a clearing pass writes all MAX_N entries
// of the store, during which no word is accepted; a restart word returns its
// result at the end of that pass. Configuration writes are taken at any time.
`include "prime_sieve_counter_unit_macros.svh"

module prime_sieve_counter_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_restart,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [psc_pkg::FIELD_W-1:0]  rsp_candidate,
   output logic                         rsp_prime_flag,
   output logic                         rsp_counted,
   output logic [psc_pkg::COUNT_W-1:0]  rsp_prime_count,
   output logic                         rsp_done_res,
   input  logic                         csr_write,
   input  logic                         csr_index,
   input  logic [psc_pkg::FIELD_W-1:0]  csr_wdata
);
   import psc_pkg::*;

   logic [FIELD_W-1:0] start_ff;
   logic [FIELD_W-1:0] stop_ff;
   logic [NUM_W-1:0]   stop_ext;
   psc_cfg_type        cfg;
   logic               core_ready;
   logic               res_free;
   logic               core_res_valid;
   psc_result_type     core_res;
   logic               rsp_valid_ff;
   psc_result_type     rsp_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= FIELD_W'(2);
         stop_ff  <= FIELD_W'(23);
      end else if (csr_write) begin
         case (csr_index)
            REG_RANGE_START: start_ff <= csr_wdata;
            REG_RANGE_STOP:  stop_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // clamp the stop to the store size
   assign stop_ext  = NUM_W'(stop_ff);
   assign cfg.start = NUM_W'(start_ff);
   assign cfg.stop  = (stop_ext < STOP_LIMIT) ? stop_ext : STOP_LIMIT;

   assign req_stall = !core_ready;
   assign res_free  = !rsp_valid_ff || !rsp_stall;

   psc_core u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .item_valid   (req_valid),
      .item_restart (req_restart),
      .item_ready   (core_ready),
      .res_free     (res_free),
      .res_valid    (core_res_valid),
      .res          (core_res)
   );

   // output word register: load a new word, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (core_res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (core_res_valid) begin
         rsp_ff <= core_res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_candidate   = rsp_ff.candidate;
   assign rsp_prime_flag  = rsp_ff.prime_flag;
   assign rsp_counted     = rsp_ff.counted;
   assign rsp_prime_count = rsp_ff.prime_count;
   assign rsp_done_res    = rsp_ff.done_res;

   // a new result never overwrites a word still waiting
   `PSC_ASSERT_IMP(a_no_overwrite, clock, reset, core_res_valid, res_free)
   // the block is busy right after taking a word
   `PSC_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // only primes are counted
   `PSC_ASSERT_IMP(a_counted_prime, clock, reset, rsp_valid && rsp_counted, rsp_prime_flag)

endmodule

>>> tb/testbench.sv
// Self-checking testbench for prime_sieve_counter_unit: random handshake gaps on both channels,
// a scoreboard fed by a sieve predictor kept inside this file.
// Depends on psc_pkg and the prime_sieve_counter_unit RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import psc_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_restart = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [FIELD_W-1:0] rsp_candidate;
   logic               rsp_prime_flag;
   logic               rsp_counted;
   logic [COUNT_W-1:0] rsp_prime_count;
   logic               rsp_done_res;
   logic               csr_write = 1'b0;
   logic               csr_index = REG_RANGE_START;
   logic [FIELD_W-1:0] csr_wdata = '0;

   // Predictor state: mark store, next number to examine, counted primes, range registers
   bit                 mark_bits [MAX_N];
   longint unsigned    sieve_next;
   logic [COUNT_W-1:0] primes_seen;
   logic [FIELD_W-1:0] count_from = 16'd2;
   logic [FIELD_W-1:0] sieve_to = 16'd23;

   // Stimulus and scoreboard
   logic           pending_restarts [$];
   psc_result_type expected_results [$];
   bit             word_in_flight = 1'b0;
   bit             rsp_taken = 1'b0;
   int             mismatches = 0;

   // Handshake pacing
   int tx_wait = 0;
   int tx_calm = 0;
   int rx_wait = 0;
   int rx_calm = 0;
   logic rx_stall = 1'b0;
   bit hold_armed = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;

   prime_sieve_counter_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_candidate  (rsp_candidate),
      .rsp_prime_flag (rsp_prime_flag),
      .rsp_counted    (rsp_counted),
      .rsp_prime_count(rsp_prime_count),
      .rsp_done_res   (rsp_done_res),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Refill the whole store as prime and start over at two
   function automatic void reset_sieve();
      foreach (mark_bits[i]) mark_bits[i] = 1'b1;
      mark_bits[0] = 1'b0;
      mark_bits[1] = 1'b0;
      sieve_next = 2;
      primes_seen = '0;
   endfunction

   // Advance the sieve by one word and return the result it produces
   function automatic psc_result_type step_sieve(input logic restart);
      psc_result_type  res;
      longint unsigned lim;
      longint unsigned cand;
      longint unsigned m;
      bit              prime;
      res = '0;
      lim = (sieve_to < MAX_N - 1) ? sieve_to : MAX_N - 1;
      if (restart) begin
         reset_sieve();
         return res;
      end
      cand = sieve_next;
      // hold once past the stop value
      if (cand > lim) begin
         res.prime_count = primes_seen;
         res.done_res = 1'b1;
         return res;
      end
      prime = (cand < MAX_N) && mark_bits[cand];
      if (prime && cand * cand <= lim) begin
         for (m = cand * cand; m <= lim; m += cand) mark_bits[m] = 1'b0;
      end
      res.counted = prime && (cand >= count_from);
      // saturate the running count
      if (res.counted && primes_seen != COUNT_MAX) primes_seen++;
      sieve_next = cand + 1;
      res.candidate = FIELD_W'(cand);
      res.prime_flag = prime;
      res.prime_count = primes_seen;
      res.done_res = (cand >= lim);
      return res;
   endfunction

   function automatic string show(psc_result_type r);
      return $sformatf("cand=%0d prime=%0b counted=%0b count=%0d done=%0b",
                       r.candidate, r.prime_flag, r.counted, r.prime_count, r.done_res);
   endfunction

   function automatic void note_error(string msg);
      if (mismatches < 10) $display("ERROR @%0t: %s", $time, msg);
      mismatches++;
   endfunction

   // Draw a wait per word; now and then run a calm stretch with no waits
   function automatic int pick_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   // Sample both channels: check results, then predict for accepted words
   always @(posedge clock) begin
      psc_result_type got;
      psc_result_type want;
      rsp_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsp_taken = 1'b1;
            got.candidate = rsp_candidate;
            got.prime_flag = rsp_prime_flag;
            got.counted = rsp_counted;
            got.prime_count = rsp_prime_count;
            got.done_res = rsp_done_res;
            if (expected_results.size() == 0) begin
               note_error($sformatf("unexpected result word %s", show(got)));
            end else begin
               want = expected_results.pop_front();
               if (got.candidate !== want.candidate || got.prime_flag !== want.prime_flag ||
                   got.counted !== want.counted || got.prime_count !== want.prime_count ||
                   got.done_res !== want.done_res) begin
                  note_error($sformatf("expected %s, got %s", show(want), show(got)));
               end
            end
         end
         if (req_valid && !req_stall) begin
            word_in_flight = 1'b0;
            expected_results.push_back(step_sieve(req_restart));
         end
      end
   end

   // Drive request words from the pending queue; hold a stalled word
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_wait = 0;
      end else if (!word_in_flight) begin
         if (tx_wait != 0) begin
            req_valid <= 1'b0;
            tx_wait--;
         end else if (pending_restarts.size() != 0) begin
            req_valid <= 1'b1;
            req_restart <= pending_restarts.pop_front();
            word_in_flight = 1'b1;
            tx_wait = pick_wait(tx_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall the result channel for a drawn number of cycles after each word
   always @(negedge clock) begin
      if (reset) begin
         rx_stall <= 1'b0;
         rx_wait = 0;
      end else begin
         if (rsp_taken) rx_wait = pick_wait(rx_calm);
         if (rx_wait != 0) begin
            rx_stall <= 1'b1;
            rx_wait--;
         end else begin
            rx_stall <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, armed once, so the block backs up into its input
   always @(negedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_armed && !hold_done) begin
         hold_left <= 400;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   assign rsp_stall = rx_stall | (hold_left != 0);

   task automatic write_reg(input logic idx, input logic [FIELD_W-1:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == REG_RANGE_START) count_from = val;
      else sieve_to = val;
   endtask

   task automatic queue_words(input int n);
      repeat (n) pending_restarts.push_back(1'b0);
   endtask

   // Wait until every word is sent and every result has come back
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_restarts.size() != 0 || word_in_flight || expected_results.size() != 0);
   endtask

   initial begin
      int n_words;
      int noise_at;
      logic [FIELD_W-1:0] lo;
      logic [FIELD_W-1:0] hi;
      bit fresh;
      reset_sieve();
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // range registers at their reset values
      queue_words(3);
      wait_drained();
      // widest range, stop raised mid-run without a restart
      write_reg(REG_RANGE_START, 16'd0);
      write_reg(REG_RANGE_STOP, 16'hFFFF);
      queue_words(9);
      wait_drained();
      // stop below two: done at once after a restart, then idle words
      write_reg(REG_RANGE_START, 16'hFFFF);
      write_reg(REG_RANGE_STOP, 16'd1);
      pending_restarts.push_back(1'b1);
      queue_words(2);
      wait_drained();
      // small range: uncounted prime below start, done, idle after done
      write_reg(REG_RANGE_START, 16'd3);
      write_reg(REG_RANGE_STOP, 16'd5);
      queue_words(5);
      wait_drained();
      // stop moved up mid-run
      write_reg(REG_RANGE_STOP, 16'd9);
      queue_words(2);
      wait_drained();

      // random ranges: mostly restart plus a run of advance words
      for (int ph = 0; ph < 6; ph++) begin
         case ($urandom_range(0, 7))
            0: hi = FIELD_W'($urandom_range(0, 1));
            1, 2: hi = FIELD_W'($urandom_range(301, 4000));
            default: hi = FIELD_W'($urandom_range(2, 300));
         endcase
         lo = ($urandom_range(0, 3) == 0) ? FIELD_W'($urandom_range(0, 65535))
                                         : FIELD_W'($urandom_range(0, hi));
         write_reg(REG_RANGE_START, lo);
         write_reg(REG_RANGE_STOP, hi);
         fresh = (ph % 3 != 2);
         if (fresh) begin
            pending_restarts.push_back(1'b1);
            wait_drained();
         end
         if (ph == 1) hold_armed = 1'b1;
         n_words = $urandom_range(280, 300);
         noise_at = (fresh && $urandom_range(0, 2) == 0) ? $urandom_range(1, n_words - 1) : -1;
         for (int i = 0; i < n_words; i++) pending_restarts.push_back(i == noise_at);
         wait_drained();
      end

      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Give up on a hung run
   initial begin
      #40_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> files.f
+incdir+src
src/psc_pkg.sv
src/psc_ram.sv
src/psc_core.sv
src/prime_sieve_counter_unit.sv
tb/testbench.sv
